// ----- design/kmc_pkg.sv -----
package kmc_pkg;

  localparam int DEF_MAX_NODES   = 256;
  localparam int DEF_MAX_EDGES   = 1024;
  localparam int DEF_WEIGHT_BITS = 16;

  localparam int NODE_IN_BITS   = 8;
  localparam int WEIGHT_IN_BITS = 16;
  localparam int CFG_BITS       = 9;
  localparam int COST_BITS      = 24;
  localparam int RANK_BITS      = 4;

  localparam logic [RANK_BITS-1:0] RANK_MAX = '1;

  typedef logic [NODE_IN_BITS-1:0] node_in_t;
  typedef logic [COST_BITS-1:0]    cost_t;
  typedef logic [RANK_BITS-1:0]    rank_t;

endpackage

// ----- design/kmc_ram.sv -----
module kmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/kruskal_mst_cost_top.sv -----
// Minimum spanning forest cost. Edges are taken one per cycle (start high, busy low)
// and written to the edge memory; an edge beyond MAX_EDGES is dropped. The edge
// with in_last_edge set starts the computation and busy stays high until the
// result: an insertion sort on the edge memory (its compares are paced by the
// single read port and its latency), a sweep over the nodes in use that resets
// the union-find memory, then per edge a fetch, a root search for each end that
// walks the parent path, and a join of one or two writes. out_tree_cost is shown
// for one cycle with out_valid; the receiver cannot stall it. Configuration is
// taken at any cycle with cfg_wr_en.
module kruskal_mst_cost_top #(
  parameter int MAX_NODES   = kmc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES   = kmc_pkg::DEF_MAX_EDGES,
  parameter int WEIGHT_BITS = kmc_pkg::DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  kmc_pkg::node_in_t             in_edge_from,
  input  kmc_pkg::node_in_t             in_edge_to,
  input  logic signed [kmc_pkg::WEIGHT_IN_BITS-1:0] in_edge_weight,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  output logic signed [kmc_pkg::COST_BITS-1:0] out_tree_cost,
  input  logic                          cfg_wr_en,
  input  logic [kmc_pkg::CFG_BITS-1:0]  cfg_wr_data
);
  import kmc_pkg::*;

  localparam int WB   = WEIGHT_BITS;
  localparam int IB   = (WB < WEIGHT_IN_BITS) ? WB : WEIGHT_IN_BITS;
  localparam int XB   = (WB > COST_BITS) ? WB : COST_BITS;
  localparam int EW   = 2 * NODE_IN_BITS + WB;
  localparam int EAW  = $clog2(MAX_EDGES);
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int NB   = $clog2(MAX_NODES);
  localparam int NCR  = $clog2(MAX_NODES + 1);
  localparam int NCW  = (NCR > CFG_BITS) ? NCR : CFG_BITS;
  localparam int UW   = NB + RANK_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_I, S_GET_I, S_J_RD, S_J_CMP, S_CLR, S_SC_RD, S_SC_GET,
    S_FA, S_FB, S_JOIN1, S_JOIN2, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [EW-1:0]       e_r, e_nxt;
  logic [NB-1:0]       x_r, x_nxt, xr_r, xr_nxt, yr_r, yr_nxt;
  rank_t               xrk_r, xrk_nxt, yrk_r, yrk_nxt;
  logic [NCW-1:0]      n_r, n_nxt;
  cost_t               cost_r, cost_nxt;
  logic [CFG_BITS-1:0] node_count_r;
  logic                out_valid_r, out_valid_nxt;
  cost_t               out_cost_r, out_cost_nxt;

  logic            e_we;
  logic [EAW-1:0]  e_waddr, e_raddr;
  logic [EW-1:0]   e_wdata, e_rdata;
  logic            u_we;
  logic [NB-1:0]   u_waddr, u_raddr;
  logic [UW-1:0]   u_wdata, u_rdata;

  logic [NCW-1:0]  nodes;
  logic [CW-1:0]   jm1;
  logic [WB-1:0]   in_w;
  logic signed [WB-1:0] ew_s, rw_s;
  logic [XB-1:0]   ew_x;
  node_in_t        ea, eb, ra, rb;
  logic [NB-1:0]   up;
  rank_t           urk;
  logic            accept;

  kmc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  kmc_ram #(.WIDTH(UW), .DEPTH(MAX_NODES)) u_forest (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign nodes  = (NCW'(node_count_r) > NCW'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                         : NCW'(node_count_r);
  assign jm1    = j_r - 1'b1;
  // wider weight than the port: value is the port's bits, zero-extended
  assign in_w   = WB'(in_edge_weight[IB-1:0]);
  assign ea     = e_r[EW-1 -: NODE_IN_BITS];
  assign eb     = e_r[EW-NODE_IN_BITS-1 -: NODE_IN_BITS];
  assign ew_s   = e_r[WB-1:0];
  assign ew_x   = XB'(ew_s);
  assign ra     = e_rdata[EW-1 -: NODE_IN_BITS];
  assign rb     = e_rdata[EW-NODE_IN_BITS-1 -: NODE_IN_BITS];
  assign rw_s   = e_rdata[WB-1:0];
  assign up     = u_rdata[UW-1 -: NB];
  assign urk    = u_rdata[RANK_BITS-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    e_nxt         = e_r;
    x_nxt         = x_r;
    xr_nxt        = xr_r;
    yr_nxt        = yr_r;
    xrk_nxt       = xrk_r;
    yrk_nxt       = yrk_r;
    n_nxt         = n_r;
    cost_nxt      = cost_r;
    out_valid_nxt = 1'b0;
    out_cost_nxt  = out_cost_r;
    e_we          = 1'b0;
    e_waddr       = cnt_r[EAW-1:0];
    e_wdata       = {in_edge_from, in_edge_to, in_w};
    e_raddr       = i_r[EAW-1:0];
    u_we          = 1'b0;
    u_waddr       = n_r[NB-1:0];
    u_wdata       = {n_r[NB-1:0], RANK_BITS'(0)};
    u_raddr       = x_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cnt_r < CW'(MAX_EDGES)) begin
            e_we    = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_last_edge) begin
            i_nxt     = CW'(1);
            state_nxt = S_RD_I;
          end
        end
      end
      S_RD_I: begin
        if (i_r >= cnt_r) begin
          n_nxt     = '0;
          cost_nxt  = '0;
          state_nxt = (nodes == '0) ? S_SC_RD : S_CLR;
          i_nxt     = '0;
        end else begin
          state_nxt = S_GET_I;
        end
      end
      S_GET_I: begin
        e_nxt     = e_rdata;
        j_nxt     = i_r;
        state_nxt = S_J_RD;
      end
      S_J_RD: begin
        if (j_r == '0) begin
          e_we      = 1'b1;
          e_waddr   = j_r[EAW-1:0];
          e_wdata   = e_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RD_I;
        end else begin
          e_raddr   = jm1[EAW-1:0];
          state_nxt = S_J_CMP;
        end
      end
      S_J_CMP: begin
        e_we    = 1'b1;
        e_waddr = j_r[EAW-1:0];
        if (rw_s > ew_s) begin
          e_wdata   = e_rdata;
          j_nxt     = jm1;
          state_nxt = S_J_RD;
        end else begin
          e_wdata   = e_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RD_I;
        end
      end
      S_CLR: begin
        u_we  = 1'b1;
        n_nxt = n_r + 1'b1;
        if (n_nxt == nodes) begin
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        state_nxt = (i_r == cnt_r) ? S_OUT : S_SC_GET;
      end
      S_SC_GET: begin
        e_nxt = e_rdata;
        if (NCW'(ra) >= nodes || NCW'(rb) >= nodes) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SC_RD;
        end else begin
          x_nxt     = NB'(ra);
          u_raddr   = NB'(ra);
          state_nxt = S_FA;
        end
      end
      S_FA: begin
        if (up == x_r) begin
          xr_nxt    = x_r;
          xrk_nxt   = urk;
          x_nxt     = NB'(eb);
          state_nxt = S_FB;
        end else begin
          x_nxt = up;
        end
        u_raddr = x_nxt;
      end
      S_FB: begin
        if (up == x_r) begin
          yr_nxt  = x_r;
          yrk_nxt = urk;
          if (x_r == xr_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_SC_RD;
          end else begin
            state_nxt = S_JOIN1;
          end
        end else begin
          x_nxt   = up;
          u_raddr = up;
        end
      end
      S_JOIN1: begin
        u_we     = 1'b1;
        cost_nxt = cost_r + ew_x[COST_BITS-1:0];
        if (xrk_r < yrk_r) begin
          u_waddr   = xr_r;
          u_wdata   = {yr_r, xrk_r};
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SC_RD;
        end else begin
          u_waddr = yr_r;
          u_wdata = {xr_r, yrk_r};
          if (xrk_r > yrk_r) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_SC_RD;
          end else begin
            state_nxt = S_JOIN2;
          end
        end
      end
      S_JOIN2: begin
        u_we      = 1'b1;
        u_waddr   = xr_r;
        u_wdata   = {xr_r, (xrk_r == RANK_MAX) ? xrk_r : xrk_r + 1'b1};
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SC_RD;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        out_cost_nxt  = cost_r;
        cnt_nxt       = '0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      node_count_r <= CFG_BITS'(MAX_NODES);
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    e_r        <= e_nxt;
    x_r        <= x_nxt;
    xr_r       <= xr_nxt;
    yr_r       <= yr_nxt;
    xrk_r      <= xrk_nxt;
    yrk_r      <= yrk_nxt;
    n_r        <= n_nxt;
    cost_r     <= cost_nxt;
    out_cost_r <= out_cost_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_tree_cost = out_cost_r;

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_collect_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_last_edge |=> !busy)
    else $error("block left idle on an edge without last flag");

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_edge |=> busy && !out_valid)
    else $error("last edge did not start the computation");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_EDGES))
    else $error("edge count beyond store depth");

  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r == '0 && !busy)
    else $error("edge store not emptied with result");

endmodule
